/* hdl/gvg_pkg.sv */
// Shared types and constants of the Gaussian vignette gain pipeline.
package gvg_pkg;

    localparam int COL_W      = 12;
    localparam int PIX_W      = 8;
    localparam int GAIN_W     = 17;
    localparam int SIZE_W     = 13;
    localparam int K_W        = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 32;

    localparam int SQ_W        = 2 * COL_W;
    localparam int D2_W        = SQ_W + 1;
    localparam int E_W         = D2_W + K_W;
    localparam int E_LIMIT_BIT = 29;
    localparam int L_W         = 31;
    localparam int PROD_W      = E_LIMIT_BIT + L_W;
    localparam int T_W         = PROD_W - 30;
    localparam int T_FRAC_W    = 24;
    localparam int N_W         = T_W - T_FRAC_W;
    localparam int NSTAGE      = 7;

    localparam logic [L_W-1:0]    LOG2E_Q30 = 31'd1549082005;
    localparam logic [PIX_W-1:0]  PIX_MAX   = 8'd255;
    localparam logic [SIZE_W-1:0] SIZE_RST  = 13'd4096;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INV_TWO_SIG  = 2'd2;

    typedef struct packed {
        logic [SIZE_W-1:0] width;
        logic [SIZE_W-1:0] height;
        logic [K_W-1:0]    k;
    } gvg_cfg_t;

endpackage

/* hdl/gvg_offset.sv */
// Range check, centre offsets and their squares (stages 0 and 1).
module gvg_offset import gvg_pkg::*;
#(
    parameter int COORD_BITS = 12
)
(
    input  logic              clk,
    input  logic [1:0]        adv,
    input  gvg_cfg_t          cfg,
    input  logic [COL_W-1:0]  col,
    input  logic [COL_W-1:0]  row,
    input  logic [PIX_W-1:0]  pixel_in,
    output logic              in_range,
    output logic [SQ_W-1:0]   sqx,
    output logic [SQ_W-1:0]   sqy,
    output logic [PIX_W-1:0]  pix
);

    localparam int CB = (COORD_BITS < COL_W) ? COORD_BITS : COL_W;
    localparam logic [COL_W-1:0] CMASK = ~({COL_W{1'b1}} << CB);

    logic [COL_W-1:0]        colm;
    logic [COL_W-1:0]        rowm;
    logic signed [COL_W:0]   dx;
    logic signed [COL_W:0]   dy;
    logic [COL_W-1:0]        adx_next;
    logic [COL_W-1:0]        ady_next;
    logic [COL_W-1:0]        adx_reg;
    logic [COL_W-1:0]        ady_reg;
    logic [PIX_W-1:0]        pix0_reg;
    logic [SQ_W-1:0]         sqx_next;
    logic [SQ_W-1:0]         sqy_next;
    logic [SQ_W-1:0]         sqx_reg;
    logic [SQ_W-1:0]         sqy_reg;
    logic [PIX_W-1:0]        pix1_reg;

    always_comb
    begin
        colm     = col & CMASK;
        rowm     = row & CMASK;
        in_range = ({1'b0, colm} < cfg.width) && ({1'b0, rowm} < cfg.height);
        dx       = $signed({1'b0, colm}) - $signed({1'b0, cfg.width[SIZE_W-1:1]});
        dy       = $signed({1'b0, rowm}) - $signed({1'b0, cfg.height[SIZE_W-1:1]});
        adx_next = dx[COL_W] ? COL_W'(-dx) : dx[COL_W-1:0];
        ady_next = dy[COL_W] ? COL_W'(-dy) : dy[COL_W-1:0];
        sqx_next = SQ_W'(adx_reg) * SQ_W'(adx_reg);
        sqy_next = SQ_W'(ady_reg) * SQ_W'(ady_reg);
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            adx_reg  <= adx_next;
            ady_reg  <= ady_next;
            pix0_reg <= pixel_in;
        end
        if (adv[1])
        begin
            sqx_reg  <= sqx_next;
            sqy_reg  <= sqy_next;
            pix1_reg <= pix0_reg;
        end
    end

    assign sqx = sqx_reg;
    assign sqy = sqy_reg;
    assign pix = pix1_reg;

endmodule

/* hdl/gvg_exponent.sv */
// Squared distance times k, then conversion to a base-2 exponent (stages 2 and 3).
module gvg_exponent import gvg_pkg::*;
(
    input  logic              clk,
    input  logic [1:0]        adv,
    input  gvg_cfg_t          cfg,
    input  logic [SQ_W-1:0]   sqx,
    input  logic [SQ_W-1:0]   sqy,
    input  logic [PIX_W-1:0]  pix_in,
    output logic [T_W-1:0]    t,
    output logic              zero,
    output logic [PIX_W-1:0]  pix
);

    logic [D2_W-1:0]    d2;
    logic [E_W-1:0]     e_next;
    logic [E_W-1:0]     e_reg;
    logic [PIX_W-1:0]   pix2_reg;
    logic [PROD_W-1:0]  prod;
    logic               zero_next;
    logic [T_W-1:0]     t_reg;
    logic               zero_reg;
    logic [PIX_W-1:0]   pix3_reg;

    always_comb
    begin
        d2        = D2_W'(sqx) + D2_W'(sqy);
        e_next    = E_W'(d2) * E_W'(cfg.k);
        zero_next = |e_reg[E_W-1:E_LIMIT_BIT];
        prod      = PROD_W'(e_reg[E_LIMIT_BIT-1:0]) * PROD_W'(LOG2E_Q30);
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            e_reg    <= e_next;
            pix2_reg <= pix_in;
        end
        if (adv[1])
        begin
            t_reg    <= prod[PROD_W-1:30];
            zero_reg <= zero_next;
            pix3_reg <= pix2_reg;
        end
    end

    assign t    = t_reg;
    assign zero = zero_reg;
    assign pix  = pix3_reg;

endmodule

/* hdl/gvg_gain.sv */
// Exponent table lookup, shift and sample scaling (stages 4 to 6).
module gvg_gain import gvg_pkg::*;
#(
    parameter int GAIN_FRAC_BITS = 16,
    parameter int EXP_TABLE_BITS = 8
)
(
    input  logic               clk,
    input  logic [2:0]         adv,
    input  logic [T_W-1:0]     t,
    input  logic               zero,
    input  logic [PIX_W-1:0]   pix_in,
    output logic [PIX_W-1:0]   pixel_out,
    output logic [GAIN_W-1:0]  gain
);

    localparam int TAB_SIZE = 1 << EXP_TABLE_BITS;
    localparam int ENT_W    = GAIN_FRAC_BITS + 1;
    localparam int SH_W     = $clog2(GAIN_FRAC_BITS);
    localparam int SHR      = (GAIN_FRAC_BITS >= 16) ? GAIN_FRAC_BITS - 16 : 0;
    localparam int SHL      = (GAIN_FRAC_BITS < 16) ? 16 - GAIN_FRAC_BITS : 0;
    localparam int P_W      = PIX_W + ENT_W;

    function automatic logic [63:0] isqrt64(input logic [63:0] val);
        logic [63:0] n;
        logic [63:0] res;
        logic [63:0] bitv;
        n    = val;
        res  = '0;
        bitv = 64'd1 << 62;
        for (int i = 0; i < 32; i++)
        begin
            if (n >= res + bitv)
            begin
                n   = n - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
            begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic logic [TAB_SIZE*ENT_W-1:0] build_tab();
        logic [63:0]               roots [EXP_TABLE_BITS+1];
        logic [63:0]               v;
        logic [63:0]               ent;
        logic [TAB_SIZE*ENT_W-1:0] tab;
        tab      = '0;
        roots[0] = 64'd1 << 31;
        for (int j = 1; j <= EXP_TABLE_BITS; j++)
        begin
            roots[j] = isqrt64(roots[j-1] << 32);
        end
        for (int i = 0; i < TAB_SIZE; i++)
        begin
            v = 64'd1 << 32;
            for (int b = 0; b < EXP_TABLE_BITS; b++)
            begin
                if (((i >> b) & 1) != 0)
                begin
                    v = (v * roots[EXP_TABLE_BITS-b]) >> 32;
                end
            end
            ent = (v + (64'd1 << (31 - GAIN_FRAC_BITS))) >> (32 - GAIN_FRAC_BITS);
            tab[i*ENT_W +: ENT_W] = ent[ENT_W-1:0];
        end
        return tab;
    endfunction

    localparam logic [TAB_SIZE*ENT_W-1:0] EXP_TAB = build_tab();

    logic [N_W-1:0]            n;
    logic [EXP_TABLE_BITS-1:0] idx;
    logic                      zero4_next;
    logic [ENT_W-1:0]          tab_reg;
    logic [SH_W-1:0]           n_reg;
    logic                      zero4_reg;
    logic [PIX_W-1:0]          pix4_reg;
    logic [ENT_W-1:0]          g_next;
    logic [ENT_W-1:0]          g_reg;
    logic [PIX_W-1:0]          pix5_reg;
    logic [P_W-1:0]            prod;
    logic [P_W-1:0]            ps;
    logic [31:0]               gext;
    logic [PIX_W-1:0]          pixel_next;
    logic [GAIN_W-1:0]         gain_next;
    logic [PIX_W-1:0]          pixel_reg;
    logic [GAIN_W-1:0]         gain_reg;

    always_comb
    begin
        n          = t[T_W-1:T_FRAC_W];
        idx        = t[T_FRAC_W-1 -: EXP_TABLE_BITS];
        zero4_next = zero || (n >= N_W'(GAIN_FRAC_BITS));
        g_next     = zero4_reg ? '0 : (tab_reg >> n_reg);
        prod       = P_W'(pix5_reg) * P_W'(g_reg);
        ps         = prod >> GAIN_FRAC_BITS;
        pixel_next = (ps > P_W'(PIX_MAX)) ? PIX_MAX : ps[PIX_W-1:0];
        gext       = 32'(g_reg);
        gain_next  = GAIN_W'((gext >> SHR) << SHL);
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            tab_reg   <= EXP_TAB[int'(idx)*ENT_W +: ENT_W];
            n_reg     <= n[SH_W-1:0];
            zero4_reg <= zero4_next;
            pix4_reg  <= pix_in;
        end
        if (adv[1])
        begin
            g_reg    <= g_next;
            pix5_reg <= pix4_reg;
        end
        if (adv[2])
        begin
            pixel_reg <= pixel_next;
            gain_reg  <= gain_next;
        end
    end

    assign pixel_out = pixel_reg;
    assign gain      = gain_reg;

endmodule

/* hdl/gaussian_vignette_gain_unit.sv */
// Top level of the Gaussian vignette gain unit: config registers, pipeline control, stages.
// Throughput: one item per cycle; seven stages with per-stage valid bits set the rate,
// and a stall holds only the stages that are full behind it.
// Items outside the image are dropped at the input and give no result.
// Reset clears all valid bits and loads width 4096, height 4096, k = 0; the table is a ROM.
module gaussian_vignette_gain_unit import gvg_pkg::*;
#(
    parameter int COORD_BITS     = 12,
    parameter int GAIN_FRAC_BITS = 16,
    parameter int EXP_TABLE_BITS = 8
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_DATA_W-1:0]   s_axis_tdata,   // col[11:0], row[23:12], pixel_in[31:24]
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_DATA_W-1:0]  m_axis_tdata    // pixel_out[7:0], gain[24:8], zero[31:25]
);

    gvg_cfg_t           cfg_reg;
    gvg_cfg_t           cfg_next;
    logic [NSTAGE-1:0]  v_reg;
    logic [NSTAGE-1:0]  v_next;
    logic [NSTAGE:0]    rdy;
    logic [NSTAGE-1:0]  adv;
    logic               in_range;
    logic [SQ_W-1:0]    sqx;
    logic [SQ_W-1:0]    sqy;
    logic [PIX_W-1:0]   pix1;
    logic [T_W-1:0]     t;
    logic               zero;
    logic [PIX_W-1:0]   pix3;
    logic [PIX_W-1:0]   pixel_out;
    logic [GAIN_W-1:0]  gain;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                REG_IMAGE_WIDTH:  cfg_next.width  = cfg_data[SIZE_W-1:0];
                REG_IMAGE_HEIGHT: cfg_next.height = cfg_data[SIZE_W-1:0];
                REG_INV_TWO_SIG:  cfg_next.k      = cfg_data[K_W-1:0];
                default:          cfg_next        = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.width  <= SIZE_RST;
            cfg_reg.height <= SIZE_RST;
            cfg_reg.k      <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // advance a stage when it is empty or the one after it moves
    always_comb
    begin
        rdy[NSTAGE] = m_axis_tready;
        for (int i = NSTAGE - 1; i >= 0; i--)
        begin
            rdy[i] = !v_reg[i] || rdy[i+1];
        end
        adv       = rdy[NSTAGE-1:0];
        v_next[0] = s_axis_tvalid && in_range;
        for (int i = 1; i < NSTAGE; i++)
        begin
            v_next[i] = v_reg[i-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            for (int i = 0; i < NSTAGE; i++)
            begin
                if (adv[i])
                begin
                    v_reg[i] <= v_next[i];
                end
            end
        end
    end

    gvg_offset #(
        .COORD_BITS (COORD_BITS)
    ) u_offset (
        .clk      (clk),
        .adv      (adv[1:0]),
        .cfg      (cfg_reg),
        .col      (s_axis_tdata[11:0]),
        .row      (s_axis_tdata[23:12]),
        .pixel_in (s_axis_tdata[31:24]),
        .in_range (in_range),
        .sqx      (sqx),
        .sqy      (sqy),
        .pix      (pix1)
    );

    gvg_exponent u_exponent (
        .clk    (clk),
        .adv    (adv[3:2]),
        .cfg    (cfg_reg),
        .sqx    (sqx),
        .sqy    (sqy),
        .pix_in (pix1),
        .t      (t),
        .zero   (zero),
        .pix    (pix3)
    );

    gvg_gain #(
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS),
        .EXP_TABLE_BITS (EXP_TABLE_BITS)
    ) u_gain (
        .clk       (clk),
        .adv       (adv[6:4]),
        .t         (t),
        .zero      (zero),
        .pix_in    (pix3),
        .pixel_out (pixel_out),
        .gain      (gain)
    );

    assign s_axis_tready = adv[0];
    assign m_axis_tvalid = v_reg[NSTAGE-1];
    assign m_axis_tdata  = {{(OUT_DATA_W - GAIN_W - PIX_W){1'b0}}, gain, pixel_out};

    a_gain_max: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (gain <= 17'd65536))
        else $error("gain above one");

    a_zero_gain: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (gain == '0)) |-> (pixel_out == '0))
        else $error("nonzero sample with zero gain");

    a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !v_reg[NSTAGE-1] |-> s_axis_tready)
        else $error("input stalled with empty output stage");

    a_drop_outside: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready && !in_range) |=> !v_reg[0])
        else $error("item outside the image entered the pipeline");

endmodule

/* bench/gaussian_vignette_gain_unit_test.sv */
// Self-checking stream testbench for the Gaussian vignette gain unit.
`timescale 1ns / 1ps

module gaussian_vignette_gain_unit_test import gvg_pkg::*;;

    localparam int FRAC_BITS    = 16;
    localparam int EXP_BITS     = 8;
    localparam int ROM_SIZE     = 1 << EXP_BITS;
    localparam int CYCLE_LIMIT  = 400000;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    typedef struct {
        logic [PIX_W-1:0]  pixel;
        logic [GAIN_W-1:0] gain;
    } pixel_shade_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    bit [SIZE_W-1:0] img_width = SIZE_RST;
    bit [SIZE_W-1:0] img_height = SIZE_RST;
    bit [K_W-1:0]    k_q = '0;
    bit [31:0]       exp_rom [ROM_SIZE];

    pixel_shade_t expected_shades [$];
    int           mismatches = 0;
    int           burst_left = 0;
    int           cycle_count = 0;
    int           stall_tick = 0;
    int           stall_mode = 0;

    gaussian_vignette_gain_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic bit [63:0] floor_sqrt(input bit [63:0] val);
        bit [63:0] root;
        bit [63:0] trial;
        root = 0;
        for (int b = 31; b >= 0; b--)
        begin
            trial = root | (64'd1 << b);
            if (trial * trial <= val)
                root = trial;
        end
        return root;
    endfunction

    function automatic void build_exp_rom();
        bit [63:0] roots [EXP_BITS+1];
        bit [63:0] v;
        roots[0] = 64'd1 << 31;
        for (int j = 1; j <= EXP_BITS; j++)
            roots[j] = floor_sqrt(roots[j-1] << 32);
        for (int i = 0; i < ROM_SIZE; i++)
        begin
            v = 64'd1 << 32;
            for (int b = 0; b < EXP_BITS; b++)
                if ((i >> b) & 1)
                    v = (v * roots[EXP_BITS-b]) >> 32;
            exp_rom[i] = 32'((v + (64'd1 << (31 - FRAC_BITS))) >> (32 - FRAC_BITS));
        end
    endfunction

    function automatic bit in_frame(input logic [COL_W-1:0] c, input logic [COL_W-1:0] r);
        return (13'(c) < img_width) && (13'(r) < img_height);
    endfunction

    function automatic pixel_shade_t predict_shade(input logic [COL_W-1:0] c,
                                                   input logic [COL_W-1:0] r,
                                                   input logic [PIX_W-1:0] p);
        pixel_shade_t res;
        longint    dx;
        longint    dy;
        bit [63:0] d2;
        bit [63:0] e;
        bit [63:0] t;
        bit [63:0] n;
        bit [63:0] g;
        bit [63:0] scaled;
        dx = longint'(c) - longint'(img_width >> 1);
        dy = longint'(r) - longint'(img_height >> 1);
        d2 = 64'(dx * dx) + 64'(dy * dy);
        if (k_q == 0)
            g = 64'd1 << FRAC_BITS;
        else if (d2 >= (64'd1 << 30))
            g = 0;
        else
        begin
            e = d2 * 64'(k_q);
            if (e >= (64'd1 << E_LIMIT_BIT))
                g = 0;
            else
            begin
                t = (e * 64'(LOG2E_Q30)) >> 30;
                n = t >> T_FRAC_W;
                if (n >= FRAC_BITS)
                    g = 0;
                else
                    g = 64'(exp_rom[t[T_FRAC_W-1 -: EXP_BITS]]) >> n;
            end
        end
        scaled = (64'(p) * g) >> FRAC_BITS;
        res.pixel = (scaled > 64'(PIX_MAX)) ? PIX_MAX : scaled[PIX_W-1:0];
        res.gain  = g[GAIN_W-1:0];
        return res;
    endfunction

    always @(negedge clk)
    begin
        stall_tick++;
        if (stall_tick % 97 == 0)
            stall_mode = $urandom_range(0, 3);
        case (stall_mode)
            0: m_axis_tready <= 1'b1;
            1: m_axis_tready <= 1'($urandom_range(0, 1));
            2: m_axis_tready <= (stall_tick % 5 != 0);
            default: m_axis_tready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("gaussian_vignette_gain_unit: mismatch");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        pixel_shade_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_shades.size() == 0)
            begin
                $display("%0t: unexpected item, expected none actual %h", $time, m_axis_tdata);
                mismatches++;
            end
            else
            begin
                want = expected_shades.pop_front();
                if (m_axis_tdata[PIX_W-1:0] !== want.pixel)
                begin
                    $display("%0t: pixel_out expected %h actual %h",
                             $time, want.pixel, m_axis_tdata[PIX_W-1:0]);
                    mismatches++;
                end
                if (m_axis_tdata[PIX_W +: GAIN_W] !== want.gain)
                begin
                    $display("%0t: gain expected %h actual %h",
                             $time, want.gain, m_axis_tdata[PIX_W +: GAIN_W]);
                    mismatches++;
                end
            end
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        case (idx)
            REG_IMAGE_WIDTH:  img_width  = val[SIZE_W-1:0];
            REG_IMAGE_HEIGHT: img_height = val[SIZE_W-1:0];
            REG_INV_TWO_SIG:  k_q        = val[K_W-1:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic send_pixel(input logic [COL_W-1:0] c, input logic [COL_W-1:0] r,
                              input logic [PIX_W-1:0] p);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                @(negedge clk);
                s_axis_tvalid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {p, r, c};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        burst_left--;
        if (in_frame(c, r))
            expected_shades.push_back(predict_shade(c, r, p));
    endtask

    task automatic drain_pipeline();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        while (expected_shades.size() != 0)
            @(posedge clk);
        repeat (NSTAGE + 4) @(posedge clk);
    endtask

    task automatic set_frame(input int w, input int h, input logic [K_W-1:0] k);
        write_reg(REG_IMAGE_WIDTH, w);
        write_reg(REG_IMAGE_HEIGHT, h);
        write_reg(REG_INV_TWO_SIG, k);
    endtask

    task automatic test_reset_defaults();
        send_pixel(12'd0, 12'd0, 8'd255);
        send_pixel(12'd4095, 12'd4095, 8'd0);
        send_pixel(12'd2048, 12'd2048, 8'd170);
        send_pixel(12'd4095, 12'd0, 8'd1);
        drain_pipeline();
    endtask

    task automatic test_frame_edges();
        set_frame(640, 480, 32'd2000);
        send_pixel(12'd320, 12'd240, 8'd255);
        send_pixel(12'd0, 12'd0, 8'd255);
        send_pixel(12'd639, 12'd479, 8'd200);
        send_pixel(12'd640, 12'd0, 8'd9);
        send_pixel(12'd0, 12'd480, 8'd9);
        send_pixel(12'd4095, 12'd4095, 8'd255);
        send_pixel(12'd100, 12'd50, 8'd128);
        drain_pipeline();
    endtask

    task automatic test_large_exponent();
        set_frame(4096, 4096, 32'hFFFF_FFFF);
        send_pixel(12'd2048, 12'd2048, 8'd255);
        send_pixel(12'd2049, 12'd2048, 8'd255);
        send_pixel(12'd0, 12'd0, 8'd255);
        drain_pipeline();
        write_reg(REG_INV_TWO_SIG, 32'h0C00_0000);
        send_pixel(12'd2049, 12'd2048, 8'd255);
        drain_pipeline();
        write_reg(REG_INV_TWO_SIG, 32'h0A80_0000);
        send_pixel(12'd2048, 12'd2049, 8'd255);
        drain_pipeline();
    endtask

    task automatic test_unused_register();
        write_reg(REG_UNUSED, 32'h0000_0000);
        send_pixel(12'd2049, 12'd2048, 8'd200);
        drain_pipeline();
    endtask

    task automatic test_empty_frame();
        set_frame(0, 4096, 32'd5000);
        send_pixel(12'd0, 12'd0, 8'd33);
        send_pixel(12'd2048, 12'd100, 8'd33);
        drain_pipeline();
        set_frame(4096, 0, 32'd5000);
        send_pixel(12'd0, 12'd0, 8'd44);
        drain_pipeline();
        set_frame(1, 1, 32'd5000);
        send_pixel(12'd0, 12'd0, 8'd77);
        send_pixel(12'd1, 12'd0, 8'd77);
        send_pixel(12'd0, 12'd1, 8'd77);
        drain_pipeline();
    endtask

    task automatic random_pixels(input int count);
        logic [COL_W-1:0] c;
        logic [COL_W-1:0] r;
        logic [PIX_W-1:0] p;
        int               pick;
        repeat (count)
        begin
            pick = $urandom_range(0, 19);
            if (pick == 0 || img_width == 0 || img_height == 0)
            begin
                c = COL_W'($urandom);
                r = COL_W'($urandom);
            end
            else
            begin
                c = COL_W'($urandom_range(0, int'(img_width) - 1));
                r = COL_W'($urandom_range(0, int'(img_height) - 1));
                if (pick == 1)
                    c = COL_W'(img_width - 1);
                else if (pick == 2)
                    r = COL_W'(img_height - 1);
            end
            pick = $urandom_range(0, 9);
            p = (pick == 0) ? 8'd255 : (pick == 1) ? 8'd0 : 8'($urandom);
            send_pixel(c, r, p);
        end
    endtask

    task automatic test_random_sweeps();
        int              w;
        int              h;
        int              kmode;
        longint          d2max;
        longint          kmax;
        logic [K_W-1:0]  k;
        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph)
                0: begin w = 4096; h = 4096; end
                1: begin w = 1; h = 4096; end
                2: begin w = 4096; h = 1; end
                3: begin w = $urandom_range(1, 64); h = $urandom_range(1, 64); end
                default: begin w = $urandom_range(1, 4096); h = $urandom_range(1, 4096); end
            endcase
            d2max = longint'(w / 2 + 1) * (w / 2 + 1) + longint'(h / 2 + 1) * (h / 2 + 1);
            kmax = (longint'(20) << 24) / d2max;
            if (kmax > 64'hFFFF_FFFF)
                kmax = 64'hFFFF_FFFF;
            kmode = (ph == 0) ? 5 : $urandom_range(0, 5);
            case (kmode)
                0: k = '0;
                1: k = 32'hFFFF_FFFF;
                2: k = $urandom;
                default: k = $urandom_range(1, 32'(kmax));
            endcase
            set_frame(w, h, k);
            random_pixels(80);
            drain_pipeline();
        end
    endtask

    initial
    begin
        build_exp_rom();
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_reset_defaults();
        test_frame_edges();
        test_large_exponent();
        test_unused_register();
        test_empty_frame();
        test_random_sweeps();
        if (mismatches == 0)
            $display("gaussian_vignette_gain_unit: match");
        else
            $display("gaussian_vignette_gain_unit: mismatch");
        $finish;
    end

endmodule
